// ===== design/upq_pkg.sv =====
// shared constants, codes and controller/datapath interface types
package upq_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int TAG_W   = 16;
   localparam int PRIO_W  = 16;
   localparam int REQ_W   = 3;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 7;

   localparam logic [REQ_W-1:0] REQ_ENQUEUE = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DEQUEUE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_CHANGE  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_LOWER = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic accept;
      logic exec;
      logic scan;
      logic shift_init;
      logic shift;
      logic pop;
      logic update;
      logic load;
   } upq_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] op;
      logic             empty;
      logic             scan_last;
      logic             shift_done;
   } upq_stat_type;

endpackage

// ===== design/upq_ctrl.sv =====
// sequencing state machine of the priority queue
module upq_ctrl
   import upq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  upq_stat_type stat,
   output upq_cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_EXEC   = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_PREP   = 7'b0001000,
      S_SHIFT  = 7'b0010000,
      S_UPDATE = 7'b0100000,
      S_FINISH = 7'b1000000
   } upq_state_type;

   upq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          needs_scan;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign needs_scan = !stat.empty && ((stat.op == REQ_DEQUEUE) || (stat.op == REQ_PEEK)
                                       || (stat.op == REQ_CHANGE));

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = needs_scan ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               priority if (stat.op == REQ_DEQUEUE) state_in = S_PREP;
               else if (stat.op == REQ_CHANGE)      state_in = S_UPDATE;
               else                                 state_in = S_FINISH;
            end
         end
         S_PREP: begin
            cmd.shift_init = 1'b1;
            state_in       = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               cmd.pop  = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            // wait for the output register to be free
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load)          rsp_valid_in = 1'b1;
      else if (!rsp_stall)            rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/upq_datapath.sv =====
// entry store, scan and shift datapath with the result register
module upq_datapath
   import upq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  upq_cmd_type              cmd,
   output upq_stat_type             stat,
   input  logic [REQ_W-1:0]         req_type,
   input  logic [TAG_W-1:0]         req_value_tag,
   input  logic signed [PRIO_W-1:0] req_priority_req,
   output logic [TAG_W-1:0]         rsp_out_tag,
   output logic signed [PRIO_W-1:0] rsp_out_priority,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]       rsp_entry_count,
   output logic                     rsp_is_empty
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CLOG_C = $clog2(CAPACITY + 1);
   localparam int CNT_W  = (CLOG_C > COUNT_W) ? CLOG_C : COUNT_W;
   localparam int WORD_W = TAG_W + PRIO_W;

   // entry store
   logic [WORD_W-1:0] mem [CAPACITY];
   logic              we, re;
   logic [IDX_W-1:0]  waddr, raddr;
   logic [WORD_W-1:0] wdata;
   logic [WORD_W-1:0] q_ff;
   logic [IDX_W-1:0]  q_idx_ff;
   logic              rv_ff;

   // request and scan state
   logic [REQ_W-1:0]         op_ff, op_in;
   logic [TAG_W-1:0]         tag_ff, tag_in;
   logic signed [PRIO_W-1:0] prio_ff, prio_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         rd_ff, rd_in;
   logic [IDX_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [TAG_W-1:0]         best_tag_ff, best_tag_in;
   logic signed [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         found_idx_ff, found_idx_in;
   logic signed [PRIO_W-1:0] found_prio_ff, found_prio_in;

   // result register
   logic [TAG_W-1:0]         out_tag_ff, out_tag_in;
   logic signed [PRIO_W-1:0] out_prio_ff, out_prio_in;
   logic [STAT_W-1:0]        out_status_ff, out_status_in;
   logic [COUNT_W-1:0]       out_count_ff, out_count_in;
   logic                     out_empty_ff, out_empty_in;

   logic [TAG_W-1:0]         q_tag;
   logic signed [PRIO_W-1:0] q_prio;
   logic                     empty, full, more_rd, better, reports;
   logic [IDX_W-1:0]         last_idx;

   assign q_tag    = q_ff[WORD_W-1:PRIO_W];
   assign q_prio   = $signed(q_ff[PRIO_W-1:0]);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign more_rd  = (rd_ff < count_ff);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   // first entry, strictly smaller priority, or a tie won by the smaller tag
   assign better   = (q_idx_ff == '0) || (q_prio < best_prio_ff)
                     || ((q_prio == best_prio_ff) && (q_tag < best_tag_ff));
   assign reports  = ((op_ff == REQ_DEQUEUE) || (op_ff == REQ_PEEK)) && (status_ff == ST_OK);

   assign stat.op         = op_ff;
   assign stat.empty      = empty;
   assign stat.scan_last  = rv_ff && (q_idx_ff == last_idx);
   assign stat.shift_done = !more_rd && !rv_ff;

   always_comb begin
      op_in         = op_ff;
      tag_in        = tag_ff;
      prio_in       = prio_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      rd_in         = rd_ff;
      wr_ptr_in     = wr_ptr_ff;
      best_tag_in   = best_tag_ff;
      best_prio_in  = best_prio_ff;
      best_idx_in   = best_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_prio_in = found_prio_ff;
      out_tag_in    = out_tag_ff;
      out_prio_in   = out_prio_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      out_empty_in  = out_empty_ff;
      we            = 1'b0;
      waddr         = '0;
      wdata         = q_ff;
      re            = 1'b0;
      raddr         = '0;

      if (cmd.accept) begin
         op_in     = req_type;
         tag_in    = req_value_tag;
         prio_in   = req_priority_req;
         status_in = ST_OK;
      end

      if (cmd.exec) begin
         found_in = 1'b0;
         rd_in    = CNT_W'(1);
         unique case (op_ff)
            REQ_ENQUEUE: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  we       = 1'b1;
                  waddr    = count_ff[IDX_W-1:0];
                  wdata    = {tag_ff, prio_ff};
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_DEQUEUE, REQ_PEEK: begin
               if (empty) status_in = ST_EMPTY;
               else       re        = 1'b1;
            end
            REQ_CHANGE: begin
               if (empty) status_in = ST_NOT_FOUND;
               else       re        = 1'b1;
            end
            REQ_CLEAR: count_in = '0;
            default: ;
         endcase
      end

      if (cmd.scan) begin
         if (rv_ff) begin
            if (better) begin
               best_tag_in  = q_tag;
               best_prio_in = q_prio;
               best_idx_in  = q_idx_ff;
            end
            // the last match wins
            if (q_tag == tag_ff) begin
               found_in      = 1'b1;
               found_idx_in  = q_idx_ff;
               found_prio_in = q_prio;
            end
         end
         if (more_rd) begin
            re    = 1'b1;
            raddr = rd_ff[IDX_W-1:0];
            rd_in = rd_ff + CNT_W'(1);
         end
      end

      if (cmd.shift_init) begin
         wr_ptr_in = best_idx_ff;
         rd_in     = CNT_W'(best_idx_ff) + CNT_W'(1);
      end

      // stream later entries down one slot
      if (cmd.shift) begin
         if (rv_ff) begin
            we        = 1'b1;
            waddr     = wr_ptr_ff;
            wdata     = q_ff;
            wr_ptr_in = wr_ptr_ff + IDX_W'(1);
         end
         if (more_rd) begin
            re    = 1'b1;
            raddr = rd_ff[IDX_W-1:0];
            rd_in = rd_ff + CNT_W'(1);
         end
      end

      if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.update) begin
         priority if (!found_ff)              status_in = ST_NOT_FOUND;
         else if (prio_ff > found_prio_ff)    status_in = ST_NOT_LOWER;
         else begin
            we    = 1'b1;
            waddr = found_idx_ff;
            wdata = {tag_ff, prio_ff};
         end
      end

      if (cmd.load) begin
         out_tag_in    = reports ? best_tag_ff : '0;
         out_prio_in   = reports ? best_prio_ff : '0;
         out_status_in = status_ff;
         out_count_in  = count_ff[COUNT_W-1:0];
         out_empty_in  = empty;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      q_ff     <= mem[raddr];
      q_idx_ff <= raddr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         rv_ff    <= re;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      prio_ff       <= prio_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      wr_ptr_ff     <= wr_ptr_in;
      best_tag_ff   <= best_tag_in;
      best_prio_ff  <= best_prio_in;
      best_idx_ff   <= best_idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_prio_ff <= found_prio_in;
      out_tag_ff    <= out_tag_in;
      out_prio_ff   <= out_prio_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
      out_empty_ff  <= out_empty_in;
   end

   assign rsp_out_tag      = out_tag_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_entry_count  = out_count_ff;
   assign rsp_is_empty     = out_empty_ff;

endmodule

// ===== design/unsorted_array_priority_queue_core.sv =====
// Priority queue over an unsorted entry store, scanned one entry per cycle.
//
// Request channel (req_valid/req_stall): req_type selects enqueue, dequeue,
// peek, change priority or clear; req_value_tag and req_priority_req carry
// the operands. Every request gives exactly one response transfer on the
// rsp_ channel with tag, priority, status, entry count and empty flag.
// One request is in work at a time; req_stall is low only while idle.
// Enqueue, clear, unused codes and any request on an empty queue skip the
// scan; peek scans, change priority scans and then updates the matched entry,
// and dequeue scans and then shifts the entries after the chosen slot.
// The scan reads the store once per entry; a dequeue then moves every
// later entry down one slot, reading one slot and writing another per cycle.
// The response sits in an output register, so the next request is taken
// while it waits; if the receiver keeps rsp_stall high, that next request
// finishes its work and holds in its final state until the register frees.
// Reset empties the queue at once and drops any pending response; store
// contents are not cleared.
module unsorted_array_priority_queue_core
   import upq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [REQ_W-1:0]         req_type,
   input  logic [TAG_W-1:0]         req_value_tag,
   input  logic signed [PRIO_W-1:0] req_priority_req,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [TAG_W-1:0]         rsp_out_tag,
   output logic signed [PRIO_W-1:0] rsp_out_priority,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]       rsp_entry_count,
   output logic                     rsp_is_empty
);

   upq_cmd_type  cmd;
   upq_stat_type stat;

   upq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   upq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_value_tag    (req_value_tag),
      .req_priority_req (req_priority_req),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_priority (rsp_out_priority),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule

// ===== design/upq_checker.sv =====
// port-level checks for the priority queue core, bound to the top level
module upq_checker
   import upq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [TAG_W-1:0]         rsp_out_tag,
   input logic signed [PRIO_W-1:0] rsp_out_priority,
   input logic [STAT_W-1:0]        rsp_status,
   input logic [COUNT_W-1:0]       rsp_entry_count,
   input logic                     rsp_is_empty
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_tag)
         && $stable(rsp_out_priority) && $stable(rsp_status)
         && $stable(rsp_entry_count) && $stable(rsp_is_empty))
      else $error("response changed while stalled");

   // only one request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_entry_count == '0)
      else $error("empty flag disagrees with entry count");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_out_tag == '0 && rsp_out_priority == '0)
      else $error("error response carries an entry");

   a_status_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_empty)
      else $error("empty status on a non-empty queue");

endmodule

bind unsorted_array_priority_queue_core upq_checker u_upq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_tag      (rsp_out_tag),
   .rsp_out_priority (rsp_out_priority),
   .rsp_status       (rsp_status),
   .rsp_entry_count  (rsp_entry_count),
   .rsp_is_empty     (rsp_is_empty)
);

// ===== verif/testbench.sv =====
// self-checking testbench for the unsorted-array priority queue core
module testbench;
   import upq_pkg::*;

   localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_CLEAR + 3'd1;
   localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = '1;
   localparam int RANDOM_ITEMS = 1300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 2 * CAPACITY_DEF + 8;
   localparam int NUM_ROWS     = 24;

   typedef struct packed {
      logic [TAG_W-1:0]         tag;
      logic signed [PRIO_W-1:0] prio;
      logic [STAT_W-1:0]        status;
      logic [COUNT_W-1:0]       count;
      logic                     empty;
   } pq_reply_type;

   typedef struct packed {
      logic [7:0]               reps;
      logic [REQ_W-1:0]         op;
      logic [TAG_W-1:0]         tag;
      logic signed [PRIO_W-1:0] prio;
      logic                     fixed;
      pq_reply_type             reply;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [REQ_W-1:0]         req_type = REQ_ENQUEUE;
   logic [TAG_W-1:0]         req_value_tag = '0;
   logic signed [PRIO_W-1:0] req_priority_req = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [TAG_W-1:0]         rsp_out_tag;
   logic signed [PRIO_W-1:0] rsp_out_priority;
   logic [STAT_W-1:0]        rsp_status;
   logic [COUNT_W-1:0]       rsp_entry_count;
   logic                     rsp_is_empty;

   // mirror of the queue contents, kept in arrival order
   logic [TAG_W-1:0]         mirror_tag [CAPACITY_DEF];
   logic signed [PRIO_W-1:0] mirror_prio [CAPACITY_DEF];
   int                       mirror_count = 0;

   pq_reply_type replies_due [$];
   int           faults = 0;
   int           idle_cycles = 0;
   bit           sender_calm = 1'b0;
   bit           receiver_calm = 1'b0;

   // rows with fixed set carry a reply that can be read off directly
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{1, REQ_DEQUEUE, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, ST_EMPTY, 7'd0, 1'b1}},
      '{1, REQ_PEEK, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, ST_EMPTY, 7'd0, 1'b1}},
      '{1, REQ_CHANGE, 16'h0005, 16'h0000, 1'b1,
        '{16'h0000, 16'h0000, ST_NOT_FOUND, 7'd0, 1'b1}},
      '{1, REQ_ENQUEUE, 16'hFFFF, 16'h7FFF, 1'b1, '{16'h0000, 16'h0000, ST_OK, 7'd1, 1'b0}},
      '{1, REQ_ENQUEUE, 16'h0000, 16'h8000, 1'b1, '{16'h0000, 16'h0000, ST_OK, 7'd2, 1'b0}},
      '{1, REQ_ENQUEUE, 16'h1234, 16'h8000, 1'b1, '{16'h0000, 16'h0000, ST_OK, 7'd3, 1'b0}},
      // tie on priority goes to the smaller tag
      '{1, REQ_PEEK, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h8000, ST_OK, 7'd3, 1'b0}},
      '{1, REQ_CHANGE, 16'hFFFF, 16'h7FFF, 1'b1, '{16'h0000, 16'h0000, ST_OK, 7'd3, 1'b0}},
      '{1, REQ_CHANGE, 16'h1234, 16'h0000, 1'b1,
        '{16'h0000, 16'h0000, ST_NOT_LOWER, 7'd3, 1'b0}},
      '{1, REQ_CHANGE, 16'hABCD, 16'h0000, 1'b1,
        '{16'h0000, 16'h0000, ST_NOT_FOUND, 7'd3, 1'b0}},
      // duplicate tag: only the later entry gets the new priority
      '{1, REQ_ENQUEUE, 16'hFFFF, 16'h0064, 1'b0, '0},
      '{1, REQ_CHANGE, 16'hFFFF, 16'hFFFB, 1'b0, '0},
      '{1, REQ_SPARE_FIRST, 16'h5555, 16'hAAAA, 1'b1,
        '{16'h0000, 16'h0000, ST_OK, 7'd4, 1'b0}},
      '{1, REQ_SPARE_LAST, 16'hAAAA, 16'h5555, 1'b1,
        '{16'h0000, 16'h0000, ST_OK, 7'd4, 1'b0}},
      '{4, REQ_DEQUEUE, 16'h0000, 16'h0000, 1'b0, '0},
      '{1, REQ_ENQUEUE, 16'h7777, 16'h0003, 1'b0, '0},
      '{1, REQ_CLEAR, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, ST_OK, 7'd0, 1'b1}},
      '{64, REQ_ENQUEUE, 16'h0100, 16'h0014, 1'b0, '0},
      '{1, REQ_ENQUEUE, 16'hBEEF, 16'h8000, 1'b1, '{16'h0000, 16'h0000, ST_FULL, 7'd64, 1'b0}},
      '{1, REQ_PEEK, 16'h0000, 16'h0000, 1'b0, '0},
      // lowered entry stays in the first slot
      '{1, REQ_CHANGE, 16'h0100, 16'h8000, 1'b0, '0},
      '{64, REQ_DEQUEUE, 16'h0000, 16'h0000, 1'b0, '0},
      '{1, REQ_DEQUEUE, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, ST_EMPTY, 7'd0, 1'b1}},
      '{1, REQ_CLEAR, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, ST_OK, 7'd0, 1'b1}}
   };

   // op mix per phase: cumulative bounds for enqueue, dequeue, peek, change, clear
   int unsigned op_bounds [3][5] = '{
      '{30, 55, 70, 95, 97},
      '{70, 78, 85, 98, 98},
      '{10, 65, 75, 95, 97}
   };

   unsorted_array_priority_queue_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_value_tag    (req_value_tag),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_priority (rsp_out_priority),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty)
   );

   always #5 clock = ~clock;

   // applies one request to the mirror and returns the reply it gives
   function automatic pq_reply_type serve_request(input logic [REQ_W-1:0] op,
                                                  input logic [TAG_W-1:0] tag,
                                                  input logic signed [PRIO_W-1:0] prio);
      pq_reply_type reply;
      int           best;
      int           hit;
      reply = '0;
      reply.status = ST_OK;
      case (op)
         REQ_ENQUEUE: begin
            if (mirror_count >= CAPACITY_DEF) begin
               reply.status = ST_FULL;
            end else begin
               mirror_tag[mirror_count] = tag;
               mirror_prio[mirror_count] = prio;
               mirror_count++;
            end
         end
         REQ_DEQUEUE, REQ_PEEK: begin
            if (mirror_count == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               best = 0;
               for (int i = 1; i < mirror_count; i++) begin
                  if (mirror_prio[i] < mirror_prio[best] ||
                      (mirror_prio[i] == mirror_prio[best] && mirror_tag[i] < mirror_tag[best]))
                     best = i;
               end
               reply.tag = mirror_tag[best];
               reply.prio = mirror_prio[best];
               if (op == REQ_DEQUEUE) begin
                  for (int i = best; i + 1 < mirror_count; i++) begin
                     mirror_tag[i] = mirror_tag[i + 1];
                     mirror_prio[i] = mirror_prio[i + 1];
                  end
                  mirror_count--;
               end
            end
         end
         REQ_CHANGE: begin
            hit = -1;
            for (int i = 0; i < mirror_count; i++) begin
               if (mirror_tag[i] == tag)
                  hit = i;
            end
            if (hit < 0)
               reply.status = ST_NOT_FOUND;
            else if (prio > mirror_prio[hit])
               reply.status = ST_NOT_LOWER;
            else
               mirror_prio[hit] = prio;
         end
         REQ_CLEAR: mirror_count = 0;
         default: ;
      endcase
      reply.count = COUNT_W'(mirror_count);
      reply.empty = (mirror_count == 0);
      return reply;
   endfunction

   task automatic send_request(input logic [REQ_W-1:0] op, input logic [TAG_W-1:0] tag,
                               input logic signed [PRIO_W-1:0] prio, input logic fixed,
                               input pq_reply_type fixed_reply);
      int           gap;
      pq_reply_type reply;
      gap = sender_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_value_tag <= tag;
      req_priority_req <= prio;
      do @(posedge clock); while (req_stall);
      reply = serve_request(op, tag, prio);
      replies_due.push_back(fixed ? fixed_reply : reply);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_due.size() != 0);
   endtask

   task automatic take_reply();
      pq_reply_type want;
      if (replies_due.size() == 0) begin
         $error("response transfer with none outstanding: tag %0h status %0d",
                rsp_out_tag, rsp_status);
         faults++;
         return;
      end
      want = replies_due.pop_front();
      if (rsp_out_tag !== want.tag) begin
         $error("out_tag: expected %0h, actual %0h", want.tag, rsp_out_tag);
         faults++;
      end
      if (rsp_out_priority !== want.prio) begin
         $error("out_priority: expected %0d, actual %0d", want.prio, rsp_out_priority);
         faults++;
      end
      if (rsp_status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, rsp_status);
         faults++;
      end
      if (rsp_entry_count !== want.count) begin
         $error("entry_count: expected %0d, actual %0d", want.count, rsp_entry_count);
         faults++;
      end
      if (rsp_is_empty !== want.empty) begin
         $error("is_empty: expected %0b, actual %0b", want.empty, rsp_is_empty);
         faults++;
      end
   endtask

   // result side: random stall before each transfer, with calm stretches
   initial begin
      int stall_len;
      int taken;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 40 == 0)
            receiver_calm = ($urandom_range(0, 3) == 0);
         stall_len = receiver_calm ? 0 : $urandom_range(0, 17);
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         take_reply();
         taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int                       mode;
      int unsigned              pick;
      int                       j;
      logic [REQ_W-1:0]         op;
      logic [TAG_W-1:0]         tag;
      logic signed [PRIO_W-1:0] prio;
      mode = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int i = 0; i < directed_rows[r].reps; i++)
            send_request(directed_rows[r].op, TAG_W'(directed_rows[r].tag + i),
                         PRIO_W'(directed_rows[r].prio - i % 5), directed_rows[r].fixed,
                         directed_rows[r].reply);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // phases: balanced, filling towards full, draining towards empty
         if (n % 100 == 0)
            mode = $urandom_range(0, 2);
         if (n % 40 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
         if (n % 250 == 125)
            hold_until_drained();
         pick = $urandom_range(0, 99);
         if (pick < op_bounds[mode][0])
            op = REQ_ENQUEUE;
         else if (pick < op_bounds[mode][1])
            op = REQ_DEQUEUE;
         else if (pick < op_bounds[mode][2])
            op = REQ_PEEK;
         else if (pick < op_bounds[mode][3])
            op = REQ_CHANGE;
         else if (pick < op_bounds[mode][4])
            op = REQ_CLEAR;
         else
            op = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));

         if (op == REQ_CHANGE && mirror_count > 0 && $urandom_range(0, 4) != 0) begin
            // aim at a held tag: lower, equal, higher or any new priority
            j = $urandom_range(0, mirror_count - 1);
            tag = mirror_tag[j];
            case ($urandom_range(0, 3))
               0: prio = PRIO_W'(mirror_prio[j] - $urandom_range(1, 200));
               1: prio = mirror_prio[j];
               2: prio = PRIO_W'(mirror_prio[j] + $urandom_range(1, 200));
               default: prio = PRIO_W'($urandom);
            endcase
         end else begin
            // narrow tags and priorities make ties and duplicates common
            tag = TAG_W'(($urandom_range(0, 9) < 4) ? $urandom_range(0, 15) : $urandom);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: prio = PRIO_W'($urandom_range(0, 8) - 4);
               4: prio = 16'h8000;
               5: prio = 16'h7FFF;
               default: prio = PRIO_W'($urandom);
            endcase
         end
         send_request(op, tag, prio, 1'b0, '0);
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (replies_due.size() != 0) begin
         $error("%0d responses never arrived", replies_due.size());
         faults++;
      end
      if (faults == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/upq_pkg.sv
design/upq_ctrl.sv
design/upq_datapath.sv
design/unsorted_array_priority_queue_core.sv
design/upq_checker.sv
verif/testbench.sv
